@@ hw/rtl/double_ended_queue_top_macros.svh @@
// Assertion macros shared by the double-ended queue RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define DEQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/deq_pkg.sv @@
// Types and constants for the double-ended queue.
// Depends on nothing; used by every module and interface of the block.
package deq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int OP_W   = 3;
    localparam int WORD_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5
    } t_op;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_LOAD = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load_out;
    } t_ctl_cmd;

endpackage

@@ hw/rtl/deq_in_if.sv @@
// Request channel of the double-ended queue: valid/ready plus request fields.
// Depends on deq_pkg.
interface deq_in_if;
    logic                                valid;
    logic                                ready;
    logic [deq_pkg::OP_W-1:0]            op;
    logic signed [deq_pkg::WORD_W-1:0]   data_value;

    modport source (output valid, output op, output data_value, input ready);
    modport sink   (input valid, input op, input data_value, output ready);
endinterface

@@ hw/rtl/deq_out_if.sv @@
// Result channel of the double-ended queue: valid/ready plus result fields.
// Depends on deq_pkg.
interface deq_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [deq_pkg::WORD_W-1:0]   read_value;
    logic [deq_pkg::CNT_W-1:0]           occupancy;
    logic                                fault;

    modport source (output valid, output read_value, output occupancy, output fault,
                    input ready);
    modport sink   (input valid, input read_value, input occupancy, input fault,
                    output ready);
endinterface

@@ hw/rtl/double_ended_queue_top.sv @@
// Double-ended queue top level: 16-word ring store with push/pop/peek at both ends.
// On accept the store is read into a read register; the result then moves to the output register once that is free.
// A new request is not taken until the pending result has moved into the output register.
// A pending result holds in the output register while the next request is accepted.
// Reset (synchronous, active low) empties the queue; store contents stay undefined.
module double_ended_queue_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    deq_in_if.sink    i_in,
    deq_out_if.source o_out
);
    import deq_pkg::*;

    t_ctl_cmd cmd;

    // Controller: owns the handshake and sequences accept -> load of the result.
    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    // Datapath: ring store addressed by front index and count, plus result register.
    deq_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_op         (i_in.op),
        .i_data_value (i_in.data_value),
        .o_read_value (o_out.read_value),
        .o_occupancy  (o_out.occupancy),
        .o_fault      (o_out.fault)
    );

endmodule

@@ hw/rtl/deq_ctrl.sv @@
// Handshake controller of the double-ended queue: state machine and result valid.
// Depends on deq_pkg and double_ended_queue_top_macros.svh.
`include "double_ended_queue_top_macros.svh"

module deq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output deq_pkg::t_ctl_cmd o_cmd
);
    import deq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                // Move the result into the output register once it is free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    `DEQ_ASSERT_NEXT(a_accept_to_load, i_clk, i_rst_n, o_cmd.accept,
        r_state == S_LOAD, "accepted item did not move to load")
    `DEQ_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, o_cmd.load_out,
        r_out_valid, "loaded result not flagged valid")
    `DEQ_ASSERT_IMPL(a_no_accept_in_load, i_clk, i_rst_n, r_state == S_LOAD,
        !o_in_ready && !o_cmd.accept, "request taken while a result is pending")

endmodule

@@ hw/rtl/deq_datapath.sv @@
// Datapath of the double-ended queue: ring store, front index, count, result register.
// Depends on deq_pkg and double_ended_queue_top_macros.svh.
`include "double_ended_queue_top_macros.svh"

module deq_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  deq_pkg::t_ctl_cmd                   i_cmd,
    input  logic [deq_pkg::OP_W-1:0]            i_op,
    input  logic signed [deq_pkg::WORD_W-1:0]   i_data_value,
    output logic signed [deq_pkg::WORD_W-1:0]   o_read_value,
    output logic [deq_pkg::CNT_W-1:0]           o_occupancy,
    output logic                                o_fault
);
    import deq_pkg::*;

    logic signed [WORD_W-1:0] mem [DEPTH];

    logic [IDX_W-1:0]         r_front;
    logic [IDX_W-1:0]         n_front;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic signed [WORD_W-1:0] r_rd_data;
    logic                     r_fault;
    logic                     r_is_read;
    logic signed [WORD_W-1:0] r_out_read_value;
    logic [CNT_W-1:0]         r_out_occupancy;
    logic                     r_out_fault;

    t_op              op;
    logic             full;
    logic             empty;
    logic             is_push;
    logic             is_read;
    logic             legal;
    logic             fault;
    logic [IDX_W-1:0] front_inc;
    logic [IDX_W-1:0] front_dec;
    logic [SUM_W-1:0] tail_sum;
    logic [IDX_W-1:0] tail_pos;
    logic [IDX_W-1:0] back_pos;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;

    always_comb begin
        op    = t_op'(i_op);
        full  = (r_count == CNT_W'(DEPTH));
        empty = (r_count == '0);
        legal = (i_op <= OP_W'(OP_PEEK_BACK));
        is_push = (op inside {OP_PUSH_FRONT, OP_PUSH_BACK});
        is_read = legal && !is_push;
        fault   = !legal || (is_push && full) || (is_read && empty);

        front_inc = (r_front == IDX_W'(DEPTH - 1)) ? '0 : r_front + 1'b1;
        front_dec = (r_front == '0) ? IDX_W'(DEPTH - 1) : r_front - 1'b1;
        tail_sum  = SUM_W'(r_front) + SUM_W'(r_count);
        tail_pos  = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(tail_sum);
        back_pos  = (tail_pos == '0) ? IDX_W'(DEPTH - 1) : tail_pos - 1'b1;

        wr_en   = 1'b0;
        wr_addr = tail_pos;
        rd_addr = r_front;
        n_front = r_front;
        n_count = r_count;
        case (op)
            OP_PUSH_FRONT: begin
                wr_addr = front_dec;
                if (!full) begin
                    wr_en   = i_cmd.accept;
                    n_front = front_dec;
                    n_count = r_count + 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (!full) begin
                    wr_en   = i_cmd.accept;
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (!empty) begin
                    n_front = front_inc;
                    n_count = r_count - 1'b1;
                end
            end
            OP_POP_BACK: begin
                rd_addr = back_pos;
                if (!empty) begin
                    n_count = r_count - 1'b1;
                end
            end
            OP_PEEK_BACK: begin
                rd_addr = back_pos;
            end
            default: begin
                // peek front and unused codes: no state change
            end
        endcase
    end

    // Ring store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_data_value;
        end
        if (i_cmd.accept) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.accept) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_fault   <= fault;
            r_is_read <= is_read && !fault;
        end
        if (i_cmd.load_out) begin
            r_out_read_value <= r_is_read ? r_rd_data : '0;
            r_out_occupancy  <= r_count;
            r_out_fault      <= r_fault;
        end
    end

    assign o_read_value = r_out_read_value;
    assign o_occupancy  = r_out_occupancy;
    assign o_fault      = r_out_fault;

    `DEQ_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(DEPTH), "entry count beyond depth")
    `DEQ_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, i_cmd.accept,
        (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1) ||
        (r_count == $past(r_count) - 1'b1), "entry count moved by more than one")
    `DEQ_ASSERT_NEXT(a_fault_keeps_state, i_clk, i_rst_n, i_cmd.accept && fault,
        $stable(r_count) && $stable(r_front), "faulted request changed the state")

endmodule
